// File: sv/bfl_pkg.sv
// ----------------------------------------------------------------------------
// bfl_pkg
// Shared types and constants of the cubic Bezier flattener.
// ----------------------------------------------------------------------------
package bfl_pkg;

  localparam int COORD_BITS   = 24;
  localparam int FRAC_BITS    = 32;
  localparam int MAX_SEGMENTS = 63;
  localparam int SEG_W        = 6;
  localparam int SEG_RESET    = 16;

  // fixed point accumulators and coefficients
  localparam int FIX_W = 64;
  // numerators up to 6*d3 (d3 bounded by 4 * 2^COORD_BITS)
  localparam int NUM_W = COORD_BITS + 6;
  // divisor up to MAX_SEGMENTS^3
  localparam int DEN_W = 3 * SEG_W;
  // dividend = (|num| << (FRAC_BITS+1)) + den
  localparam int DIV_W     = 64;
  localparam int DIV_RADIX = 4;
  localparam int DIV_CYC   = DIV_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // coefficient slots per axis
  localparam int COEF_CNT = 6;
  localparam logic [2:0] COEF_D    = 3'd0;
  localparam logic [2:0] COEF_DD   = 3'd1;
  localparam logic [2:0] COEF_DD2  = 3'd2;
  localparam logic [2:0] COEF_DDD  = 3'd3;
  localparam logic [2:0] COEF_DDD2 = 3'd4;
  localparam logic [2:0] COEF_DDD6 = 3'd5;

  typedef enum logic [1:0] {
    VSEL_START = 2'd0,
    VSEL_MID   = 2'd1,
    VSEL_END   = 2'd2
  } vsel_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] ctrl1_x;
    logic signed [COORD_BITS-1:0] ctrl1_y;
    logic signed [COORD_BITS-1:0] ctrl2_x;
    logic signed [COORD_BITS-1:0] ctrl2_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         new_shape;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         skip;
    logic                         last_of_curve;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       diff;
    logic       cube;
    logic       div_start;
    logic       div_store;
    logic       axis;
    logic [2:0] coef;
    logic       step;
    logic       emit;
    vsel_t      vsel;
  } cmd_t;

  typedef struct packed {
    logic             div_done;
    logic             out_free;
    logic [SEG_W-1:0] seg;
  } sts_t;

endpackage

// File: sv/bfl_div.sv
// ----------------------------------------------------------------------------
// bfl_div
// Restoring divider, DIV_RADIX quotient bits per cycle, rounded fixed point.
// ----------------------------------------------------------------------------
module bfl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bfl_pkg::NUM_W-1:0]   mag,
  input  logic [bfl_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [bfl_pkg::DIV_W-1:0]   quot
);
  import bfl_pkg::*;

  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  always_comb begin
    logic [DEN_W:0] t;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    for (int i = 0; i < DIV_RADIX; i++) begin
      t       = {rem_nxt, dvd_nxt[DIV_W-1]};
      dvd_nxt = {dvd_nxt[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        rem_nxt    = DEN_W'(t - {1'b0, den_r});
        dvd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = t[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // bias by den so the halved truncating quotient rounds half up
        dvd_r  <= DIV_W'({mag, {(FRAC_BITS+1){1'b0}}}) + DIV_W'(den);
        rem_r  <= '0;
        den_r  <= den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  // halve: the dividend carries one extra fraction bit
  assign quot = {1'b0, dvd_r[DIV_W-1:1]};

endmodule

// File: sv/bfl_datapath.sv
// ----------------------------------------------------------------------------
// bfl_datapath
// Control points, difference coefficients, accumulators and result register.
// ----------------------------------------------------------------------------
module bfl_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bfl_pkg::cmd_t               cmd,
  output bfl_pkg::sts_t               sts,
  input  bfl_pkg::in_t                in_data,
  input  logic                        cfg_valid,
  input  logic [bfl_pkg::SEG_W-1:0]   cfg_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bfl_pkg::out_t               out_data
);
  import bfl_pkg::*;

  localparam int IP_W = FIX_W - FRAC_BITS + 1;

  logic [SEG_W-1:0]   seg_r;
  logic [SEG_W-1:0]   n_r;
  logic [2*SEG_W-1:0] n2_r;
  logic [DEN_W-1:0]   n3_r;
  in_t                pt_r;

  logic signed [NUM_W-1:0] d1_r [2];
  logic signed [NUM_W-1:0] d2_r [2];
  logic signed [NUM_W-1:0] d3_r [2];
  logic [FIX_W-1:0]        acc_r [2];
  logic [FIX_W-1:0]        coef_r [2][COEF_CNT];
  logic                    neg_r;

  logic signed [COORD_BITS-1:0] last_x_r, last_y_r;
  logic                         have_last_r;
  logic                         out_valid_r;
  out_t                         out_r;

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [DEN_W-1:0]        den;
  logic                    div_done;
  logic [DIV_W-1:0]        quot;

  function automatic logic signed [NUM_W-1:0] sx(input logic signed [COORD_BITS-1:0] c);
    return {{(NUM_W-COORD_BITS){c[COORD_BITS-1]}}, c};
  endfunction

  // fixed point to integer, half away from zero, saturated
  function automatic logic signed [COORD_BITS-1:0] fix_round(input logic [FIX_W-1:0] v);
    logic             neg;
    logic [FIX_W-1:0] m;
    logic [IP_W-1:0]  ip;
    neg = v[FIX_W-1];
    m   = neg ? (~v + 1'b1) : v;
    ip  = IP_W'(m[FIX_W-1:FRAC_BITS]) + IP_W'(m[FRAC_BITS-1]);
    if (neg) begin
      if (ip > (IP_W'(1) << (COORD_BITS-1))) begin
        return {1'b1, {(COORD_BITS-1){1'b0}}};
      end
      return COORD_BITS'(~ip + 1'b1);
    end
    if (ip > ((IP_W'(1) << (COORD_BITS-1)) - 1'b1)) begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return COORD_BITS'(ip);
  endfunction

  // numerator and divisor of the current coefficient
  always_comb begin
    logic signed [NUM_W-1:0] d1, d2, d3;
    d1 = d1_r[cmd.axis];
    d2 = d2_r[cmd.axis];
    d3 = d3_r[cmd.axis];
    num = d3;
    den = n3_r;
    unique case (cmd.coef)
      COEF_D:    begin num = (d1 <<< 1) + d1; den = DEN_W'(n_r);  end
      COEF_DD:   begin num = (d2 <<< 2) + (d2 <<< 1); den = DEN_W'(n2_r); end
      COEF_DD2:  begin num = (d2 <<< 1) + d2; den = DEN_W'(n2_r); end
      COEF_DDD:  begin num = (d3 <<< 2) + (d3 <<< 1); end
      COEF_DDD2: begin num = (d3 <<< 1) + d3; end
      default:   begin num = d3; end
    endcase
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  bfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .mag   (mag),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  // vertex to emit and its skip flag
  logic signed [COORD_BITS-1:0] vx, vy;
  logic                         skip;
  always_comb begin
    unique case (cmd.vsel)
      VSEL_START: begin vx = pt_r.start_x; vy = pt_r.start_y; end
      VSEL_MID:   begin vx = fix_round(acc_r[0]); vy = fix_round(acc_r[1]); end
      default:    begin vx = pt_r.end_x; vy = pt_r.end_y; end
    endcase
    skip = have_last_r && (vx == last_x_r) && (vy == last_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_W'(SEG_RESET);
      have_last_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seg_r <= cfg_data;
      end
      if (cmd.load && in_data.new_shape) begin
        have_last_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (!skip) begin
          last_x_r    <= vx;
          last_y_r    <= vy;
          have_last_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_r <= in_data;
      if (seg_r == '0) begin
        n_r <= SEG_W'(1);
      end else if (seg_r > SEG_W'(MAX_SEGMENTS)) begin
        n_r <= SEG_W'(MAX_SEGMENTS);
      end else begin
        n_r <= seg_r;
      end
    end
    if (cmd.diff) begin
      n2_r     <= n_r * n_r;
      d1_r[0]  <= sx(pt_r.ctrl1_x) - sx(pt_r.start_x);
      d1_r[1]  <= sx(pt_r.ctrl1_y) - sx(pt_r.start_y);
      d2_r[0]  <= sx(pt_r.start_x) - (sx(pt_r.ctrl1_x) <<< 1) + sx(pt_r.ctrl2_x);
      d2_r[1]  <= sx(pt_r.start_y) - (sx(pt_r.ctrl1_y) <<< 1) + sx(pt_r.ctrl2_y);
      d3_r[0]  <= ((sx(pt_r.ctrl1_x) - sx(pt_r.ctrl2_x)) <<< 1)
                  + (sx(pt_r.ctrl1_x) - sx(pt_r.ctrl2_x))
                  + sx(pt_r.end_x) - sx(pt_r.start_x);
      d3_r[1]  <= ((sx(pt_r.ctrl1_y) - sx(pt_r.ctrl2_y)) <<< 1)
                  + (sx(pt_r.ctrl1_y) - sx(pt_r.ctrl2_y))
                  + sx(pt_r.end_y) - sx(pt_r.start_y);
      acc_r[0] <= {{(FIX_W-COORD_BITS-FRAC_BITS){pt_r.start_x[COORD_BITS-1]}},
                   pt_r.start_x, {FRAC_BITS{1'b0}}};
      acc_r[1] <= {{(FIX_W-COORD_BITS-FRAC_BITS){pt_r.start_y[COORD_BITS-1]}},
                   pt_r.start_y, {FRAC_BITS{1'b0}}};
    end
    if (cmd.cube) begin
      n3_r <= n2_r * n_r;
    end
    if (cmd.div_start) begin
      neg_r <= num[NUM_W-1];
    end
    if (cmd.div_store) begin
      coef_r[cmd.axis][cmd.coef] <= neg_r ? (~quot + 1'b1) : quot;
    end
    if (cmd.step) begin
      for (int a = 0; a < 2; a++) begin
        acc_r[a] <= acc_r[a] + coef_r[a][COEF_D] + coef_r[a][COEF_DD2]
                    + coef_r[a][COEF_DDD6];
        coef_r[a][COEF_D]   <= coef_r[a][COEF_D] + coef_r[a][COEF_DD]
                               + coef_r[a][COEF_DDD2];
        coef_r[a][COEF_DD]  <= coef_r[a][COEF_DD] + coef_r[a][COEF_DDD];
        coef_r[a][COEF_DD2] <= coef_r[a][COEF_DD2] + coef_r[a][COEF_DDD2];
      end
    end
    if (cmd.emit) begin
      out_r.vertex_x      <= vx;
      out_r.vertex_y      <= vy;
      out_r.skip          <= skip;
      out_r.last_of_curve <= (cmd.vsel == VSEL_END);
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.seg      = n_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// File: sv/bfl_ctrl.sv
// ----------------------------------------------------------------------------
// bfl_ctrl
// Sequencer: setup, coefficient divisions, vertex emission.
// ----------------------------------------------------------------------------
module bfl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output bfl_pkg::cmd_t cmd,
  input  bfl_pkg::sts_t sts
);
  import bfl_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_CUBE  = 9'b000000100,
    S_DGO   = 9'b000001000,
    S_DWAIT = 9'b000010000,
    S_START = 9'b000100000,
    S_STEP  = 9'b001000000,
    S_MID   = 9'b010000000,
    S_END   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic             axis_r, axis_nxt;
  logic [2:0]       coef_r, coef_nxt;
  logic [SEG_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    coef_nxt  = coef_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    cmd.coef  = coef_r;
    cmd.vsel  = VSEL_START;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube  = 1'b1;
        axis_nxt  = 1'b0;
        coef_nxt  = COEF_D;
        state_nxt = (sts.seg == SEG_W'(1)) ? S_START : S_DGO;
      end
      S_DGO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = S_DGO;
          if (coef_r == COEF_DDD6) begin
            coef_nxt = COEF_D;
            axis_nxt = 1'b1;
            if (axis_r) begin
              state_nxt = S_START;
            end
          end else begin
            coef_nxt = coef_r + 1'b1;
          end
        end
      end
      S_START: begin
        step_nxt = SEG_W'(1);
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = (sts.seg == SEG_W'(1)) ? S_END : S_STEP;
        end
      end
      S_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = S_MID;
      end
      S_MID: begin
        cmd.vsel = VSEL_MID;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (step_r == sts.seg - 1'b1) begin
            state_nxt = S_END;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = S_STEP;
          end
        end
      end
      S_END: begin
        cmd.vsel = VSEL_END;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
      coef_r  <= COEF_D;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      coef_r  <= coef_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: sv/cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Flattens cubic Bezier curves into polylines by forward differencing.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries a curve (four control points, new_shape flag).
//   out_* : segment_count+1 vertex beats per curve; the end point has
//           last_of_curve set. A vertex equal to the last kept vertex is
//           still sent, with skip set. new_shape forgets the kept vertex.
//   cfg_* : writes segment_count (0 acts as 1); always ready. Write only
//           while no curve is in flight.
// Sequence per curve, n segments:
//   n = 1 : load, differences, n^3, then the two endpoint beats.
//   n > 1 : load, differences, n^3, twelve divisions, then n + 1 vertex beats.
//   The twelve starting coefficients (six per axis) share one divider
//   that retires 4 quotient bits per cycle over a 64-bit dividend; it
//   sets most of the curve time. Each interior vertex then takes an advance
//   step, then an emit.
// One curve is worked at a time; in_ready is high only between curves.
// A stalled receiver holds the output register and freezes emission; the
// next vertex waits in the datapath. Reset (rst_n, synchronous) returns to
// idle, sets segment_count to 16 and clears the kept vertex.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bfl_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bfl_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfl_pkg::SEG_W-1:0]   cfg_data
);
  import bfl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // the segment register takes a write on any cycle
  assign cfg_ready = 1'b1;

  // sequence setup, divisions and emission
  bfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // hold points, coefficients, accumulators and the result beat
  bfl_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
